FILE: hdl/tcgr_pkg.sv
package tcgr_pkg;

    localparam int GLYPH_ROWS_DEF  = 16;
    localparam int FONT_BYTES_DEF  = 8192;
    localparam int QUEUE_DEPTH     = 2;

    localparam int COL_W    = 12;
    localparam int ROW_W    = 16;
    localparam int CODE_W   = 8;
    localparam int FADDR_W  = 13;
    localparam int ADDR_W   = 29;
    localparam int PIX_W    = 32;
    localparam int SW_W     = 13;
    localparam int PITCH_W  = 14;
    localparam int STRIDE_W = 6;
    localparam int BASE_W   = 14;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 288;

    localparam logic [PIX_W-1:0]    FG_RESET     = 32'h00FF_FFFF;
    localparam logic [PIX_W-1:0]    BG_RESET     = 32'h0000_0000;
    localparam logic [SW_W-1:0]     SW_RESET     = 13'd640;
    localparam logic [PITCH_W-1:0]  PITCH_RESET  = 14'd640;
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 6'd16;

    localparam logic [CODE_W-1:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [CODE_W-1:0] CHAR_BACKSPACE = 8'd8;

    typedef enum logic [2:0] {
        KIND_FONT_LOAD = 3'd0,
        KIND_PRINT     = 3'd1,
        KIND_PLACE     = 3'd2,
        KIND_SET_X     = 3'd3,
        KIND_NEWLINE   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        REG_FG_COLOR     = 3'd0,
        REG_BG_COLOR     = 3'd1,
        REG_SCREEN_WIDTH = 3'd2,
        REG_ROW_PITCH    = 3'd3,
        REG_GLYPH_STRIDE = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic               is_font;
        logic               erase;
        logic [CODE_W-1:0]  code;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [FADDR_W-1:0] font_addr;
        logic [7:0]         font_byte;
    } cmd_t;

endpackage

FILE: hdl/tcgr_queue.sv
module tcgr_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  tcgr_pkg::cmd_t    push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output tcgr_pkg::cmd_t    head_cmd
);

    localparam int DEPTH = tcgr_pkg::QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    tcgr_pkg::cmd_t entry_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  rd_ptr_reg;
    logic [AW:0]    count_reg;

    assign full      = (count_reg == (AW+1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                entry_reg[wr_ptr_reg] <= push_cmd;
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: hdl/tcgr_front.sv
module tcgr_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tcgr_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [2:0]                          s_tuser,
    input  logic [tcgr_pkg::SW_W-1:0]           screen_width,
    input  logic                                q_full,
    output logic                                q_push,
    output tcgr_pkg::cmd_t                      q_cmd
);

    logic [tcgr_pkg::COL_W-1:0]   col_reg, col_next;
    logic [tcgr_pkg::ROW_W-1:0]   row_reg, row_next;

    logic                         accept;
    logic [tcgr_pkg::CODE_W-1:0]  in_code;
    logic [tcgr_pkg::COL_W-1:0]   in_x;
    logic [tcgr_pkg::ROW_W-1:0]   in_y;
    logic [tcgr_pkg::FADDR_W-1:0] in_faddr;
    logic [7:0]                   in_fbyte;
    logic [tcgr_pkg::COL_W:0]     adv_col;
    logic [tcgr_pkg::COL_W+1:0]   adv_end;
    logic [tcgr_pkg::ROW_W-1:0]   row_down;
    logic [tcgr_pkg::ROW_W-1:0]   row_up;
    logic [tcgr_pkg::SW_W-1:0]    sw_less;
    logic [tcgr_pkg::COL_W-1:0]   wrap_col;
    logic [tcgr_pkg::COL_W-1:0]   back_col;
    logic [tcgr_pkg::COL_W-1:0]   back_wrap_col;
    logic                         want_push;

    assign in_code  = s_tdata[7:0];
    assign in_x     = s_tdata[19:8];
    assign in_y     = s_tdata[35:20];
    assign in_faddr = s_tdata[48:36];
    assign in_fbyte = s_tdata[56:49];

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept && want_push;

    assign adv_col  = {1'b0, col_reg} + (tcgr_pkg::COL_W+1)'(8);
    assign adv_end  = {1'b0, adv_col} + (tcgr_pkg::COL_W+2)'(8);
    assign row_down = row_reg + tcgr_pkg::ROW_W'(16);
    assign row_up   = (row_reg >= tcgr_pkg::ROW_W'(16)) ? row_reg - tcgr_pkg::ROW_W'(16) : '0;
    assign sw_less  = screen_width - tcgr_pkg::SW_W'(8);
    assign back_col = (col_reg >= tcgr_pkg::COL_W'(8)) ? col_reg - tcgr_pkg::COL_W'(8) : '0;
    assign back_wrap_col = (wrap_col >= tcgr_pkg::COL_W'(8)) ?
                           wrap_col - tcgr_pkg::COL_W'(8) : '0;

    always_comb begin
        if (screen_width < tcgr_pkg::SW_W'(8)) begin
            wrap_col = '0;
        end else if (sw_less > tcgr_pkg::SW_W'(4095)) begin
            wrap_col = '1;
        end else begin
            wrap_col = sw_less[tcgr_pkg::COL_W-1:0];
        end
    end

    always_comb begin
        col_next          = col_reg;
        row_next          = row_reg;
        want_push         = 1'b0;
        q_cmd.is_font     = 1'b0;
        q_cmd.erase       = 1'b0;
        q_cmd.code        = in_code;
        q_cmd.col         = col_reg;
        q_cmd.row         = row_reg;
        q_cmd.font_addr   = in_faddr;
        q_cmd.font_byte   = in_fbyte;
        unique case (s_tuser)
            tcgr_pkg::KIND_FONT_LOAD: begin
                want_push     = 1'b1;
                q_cmd.is_font = 1'b1;
            end
            tcgr_pkg::KIND_PRINT: begin
                if (in_code == tcgr_pkg::CHAR_NEWLINE) begin
                    col_next = '0;
                    row_next = row_down;
                end else if (in_code == tcgr_pkg::CHAR_BACKSPACE) begin
                    if (col_reg != '0) begin
                        col_next    = back_col;
                        want_push   = 1'b1;
                        q_cmd.erase = 1'b1;
                        q_cmd.col   = back_col;
                    end else if (row_reg != '0) begin
                        row_next  = row_up;
                        q_cmd.row = row_up;
                        if (wrap_col == '0) begin
                            col_next = '0;
                        end else begin
                            col_next    = back_wrap_col;
                            want_push   = 1'b1;
                            q_cmd.erase = 1'b1;
                            q_cmd.col   = back_wrap_col;
                        end
                    end
                end else begin
                    want_push = 1'b1;
                    if (adv_end > {1'b0, screen_width}) begin
                        col_next = '0;
                        row_next = row_down;
                    end else begin
                        col_next = adv_col[tcgr_pkg::COL_W-1:0];
                    end
                end
            end
            tcgr_pkg::KIND_PLACE: begin
                want_push = 1'b1;
                q_cmd.col = in_x;
                q_cmd.row = in_y;
            end
            tcgr_pkg::KIND_SET_X: begin
                col_next = in_x;
            end
            tcgr_pkg::KIND_NEWLINE: begin
                col_next = '0;
                row_next = row_down;
            end
            default: begin
                want_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

FILE: hdl/tcgr_back.sv
module tcgr_back #(
    parameter int GLYPH_ROWS = tcgr_pkg::GLYPH_ROWS_DEF,
    parameter int FONT_BYTES = tcgr_pkg::FONT_BYTES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_not_empty,
    input  tcgr_pkg::cmd_t                      q_cmd,
    output logic                                q_pop,
    input  logic [tcgr_pkg::PIX_W-1:0]          fg_color,
    input  logic [tcgr_pkg::PIX_W-1:0]          bg_color,
    input  logic [tcgr_pkg::PITCH_W-1:0]        row_pitch,
    input  logic [tcgr_pkg::STRIDE_W-1:0]       glyph_stride,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tcgr_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast
);

    localparam int FAW = $clog2(FONT_BYTES);
    localparam int RW  = $clog2(GLYPH_ROWS);
    localparam int AW  = tcgr_pkg::ADDR_W;
    localparam int BW  = tcgr_pkg::BASE_W;
    localparam int PW  = tcgr_pkg::PIX_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_ROWS
    } state_t;

    state_t          state_reg;
    logic [7:0]      font_mem [FONT_BYTES];
    logic [7:0]      rd_data_reg;
    logic [BW-1:0]   base_reg;
    logic [FAW-1:0]  fa_reg;
    logic [RW-1:0]   rcnt_reg;
    logic [AW-1:0]   addr_reg;
    logic            erase_reg;
    logic            p1_valid_reg;
    logic [AW-1:0]   p1_addr_reg;
    logic            p1_last_reg;
    logic            p1_erase_reg;
    logic            m_valid_reg;
    logic [AW-1:0]   m_addr_reg;
    logic            m_last_reg;
    logic [PW-1:0]   pix_reg [8];
    logic [PW-1:0]   pix_next [8];

    logic            advance;
    logic            issue;
    logic            row_last;
    logic            wr_en;
    logic [BW-1:0]   load_addr;
    logic [FAW-1:0]  wr_addr;
    logic [7:0]      bits;
    logic [30:0]     start_addr;

    assign advance  = !m_valid_reg || m_tready;
    assign issue    = (state_reg == ST_ROWS) && advance;
    assign row_last = (rcnt_reg == RW'(GLYPH_ROWS-1));
    assign q_pop    = (state_reg == ST_IDLE) && q_not_empty;
    assign wr_en    = q_pop && q_cmd.is_font;

    assign load_addr = {1'b0, q_cmd.font_addr};
    assign wr_addr   = (load_addr >= BW'(FONT_BYTES)) ?
                       FAW'(load_addr - BW'(FONT_BYTES)) : FAW'(load_addr);
    assign start_addr = 31'(q_cmd.row) * 31'(row_pitch) + 31'(q_cmd.col);

    assign bits = p1_erase_reg ? 8'd0 : rd_data_reg;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            pix_next[k] = bits[7-k] ? fg_color : bg_color;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            font_mem[wr_addr] <= q_cmd.font_byte;
        end
        if (advance) begin
            rd_data_reg <= font_mem[fa_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (advance) begin
                m_valid_reg  <= p1_valid_reg;
                p1_valid_reg <= issue;
                if (p1_valid_reg) begin
                    m_addr_reg <= p1_addr_reg;
                    m_last_reg <= p1_last_reg;
                    for (int k = 0; k < 8; k++) begin
                        pix_reg[k] <= pix_next[k];
                    end
                end
                if (issue) begin
                    p1_addr_reg  <= addr_reg;
                    p1_last_reg  <= row_last;
                    p1_erase_reg <= erase_reg;
                end
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_not_empty && !q_cmd.is_font) begin
                        erase_reg <= q_cmd.erase;
                        base_reg  <= BW'({6'd0, q_cmd.code} * {8'd0, glyph_stride});
                        addr_reg  <= start_addr[AW-1:0];
                        state_reg <= ST_REDUCE;
                    end
                end
                ST_REDUCE: begin
                    if (base_reg >= BW'(FONT_BYTES)) begin
                        base_reg <= base_reg - BW'(FONT_BYTES);
                    end else begin
                        fa_reg    <= base_reg[FAW-1:0];
                        rcnt_reg  <= '0;
                        state_reg <= ST_ROWS;
                    end
                end
                ST_ROWS: begin
                    if (advance) begin
                        addr_reg <= addr_reg + AW'(row_pitch);
                        fa_reg   <= (fa_reg == FAW'(FONT_BYTES-1)) ? '0 : fa_reg + 1'b1;
                        rcnt_reg <= rcnt_reg + 1'b1;
                        if (row_last) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;

    always_comb begin
        m_tdata = '0;
        m_tdata[AW-1:0] = m_addr_reg;
        for (int k = 0; k < 8; k++) begin
            m_tdata[AW + PW*k +: PW] = pix_reg[k];
        end
    end

endmodule

FILE: hdl/text_console_glyph_renderer_unit.sv
// Text console that draws bitmap-font cells into a linear framebuffer and keeps a
// text cursor. Font bytes are loaded through the input stream first; a glyph row
// must be loaded before it is drawn, since the font store is not cleared at reset.
// Set-x, newline and other cursor-only requests finish in the front, unqueued;
// a font load also passes the queue and is written when the back end pops it.
// Printing, placing or erasing a cell emits GLYPH_ROWS row writes at one per cycle
// from the font store read port while the output does not stall, after setup in
// the back end (the address multiply, then folding the glyph base into the font
// store range by repeated subtraction). Each row write leaves through a two-stage
// output pipeline. Configuration registers should be written only while no
// request is in flight.
module text_console_glyph_renderer_unit #(
    parameter int GLYPH_ROWS = tcgr_pkg::GLYPH_ROWS_DEF,
    parameter int FONT_BYTES = tcgr_pkg::FONT_BYTES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [2:0]                          cfg_wr_idx,
    input  logic [tcgr_pkg::PIX_W-1:0]          cfg_wr_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // char_code, pos_x, pos_y, font_addr, font_byte, zero fill
    input  logic [tcgr_pkg::S_TDATA_W-1:0]      s_tdata,
    // kind
    input  logic [2:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // pixel_addr, pixel0 .. pixel7, zero fill
    output logic [tcgr_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast
);

    logic [tcgr_pkg::PIX_W-1:0]    fg_reg;
    logic [tcgr_pkg::PIX_W-1:0]    bg_reg;
    logic [tcgr_pkg::SW_W-1:0]     sw_reg;
    logic [tcgr_pkg::PITCH_W-1:0]  pitch_reg;
    logic [tcgr_pkg::STRIDE_W-1:0] stride_reg;

    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_not_empty;
    tcgr_pkg::cmd_t push_cmd;
    tcgr_pkg::cmd_t head_cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_reg     <= tcgr_pkg::FG_RESET;
            bg_reg     <= tcgr_pkg::BG_RESET;
            sw_reg     <= tcgr_pkg::SW_RESET;
            pitch_reg  <= tcgr_pkg::PITCH_RESET;
            stride_reg <= tcgr_pkg::STRIDE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_idx)
                tcgr_pkg::REG_FG_COLOR:     fg_reg     <= cfg_wr_data;
                tcgr_pkg::REG_BG_COLOR:     bg_reg     <= cfg_wr_data;
                tcgr_pkg::REG_SCREEN_WIDTH: sw_reg     <= cfg_wr_data[tcgr_pkg::SW_W-1:0];
                tcgr_pkg::REG_ROW_PITCH:    pitch_reg  <= cfg_wr_data[tcgr_pkg::PITCH_W-1:0];
                tcgr_pkg::REG_GLYPH_STRIDE: stride_reg <= cfg_wr_data[tcgr_pkg::STRIDE_W-1:0];
                default: begin
                    fg_reg <= fg_reg;
                end
            endcase
        end
    end

    tcgr_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .screen_width (sw_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (push_cmd)
    );

    tcgr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    tcgr_back #(
        .GLYPH_ROWS (GLYPH_ROWS),
        .FONT_BYTES (FONT_BYTES)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_not_empty  (q_not_empty),
        .q_cmd        (head_cmd),
        .q_pop        (q_pop),
        .fg_color     (fg_reg),
        .bg_color     (bg_reg),
        .row_pitch    (pitch_reg),
        .glyph_stride (stride_reg),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

endmodule

FILE: tb/text_console_glyph_renderer_unit_test.sv
`timescale 1ns / 100ps

module text_console_glyph_renderer_unit_test;

    localparam int CELL_ROWS    = tcgr_pkg::GLYPH_ROWS_DEF;
    localparam int FONT_SIZE    = tcgr_pkg::FONT_BYTES_DEF;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 18;
    localparam int CYCLE_LIMIT  = 600000;

    localparam int COL_W     = tcgr_pkg::COL_W;
    localparam int ROW_W     = tcgr_pkg::ROW_W;
    localparam int CODE_W    = tcgr_pkg::CODE_W;
    localparam int FADDR_W   = tcgr_pkg::FADDR_W;
    localparam int ADDR_W    = tcgr_pkg::ADDR_W;
    localparam int PIX_W     = tcgr_pkg::PIX_W;
    localparam int SW_W      = tcgr_pkg::SW_W;
    localparam int PITCH_W   = tcgr_pkg::PITCH_W;
    localparam int STRIDE_W  = tcgr_pkg::STRIDE_W;
    localparam int S_TDATA_W = tcgr_pkg::S_TDATA_W;
    localparam int M_TDATA_W = tcgr_pkg::M_TDATA_W;

    // char_code, pos_x, pos_y, font_addr, font_byte from the lowest bit up
    typedef struct packed {
        logic [7:0]         font_byte;
        logic [FADDR_W-1:0] font_addr;
        logic [ROW_W-1:0]   pos_y;
        logic [COL_W-1:0]   pos_x;
        logic [CODE_W-1:0]  char_code;
    } req_fields_t;

    typedef struct packed {
        logic [ADDR_W-1:0]      addr;
        logic [7:0][PIX_W-1:0]  pix;
        logic                   last;
    } row_write_t;

    class console_shadow;
        logic [PIX_W-1:0]    fg;
        logic [PIX_W-1:0]    bg;
        logic [SW_W-1:0]     width;
        logic [PITCH_W-1:0]  pitch;
        logic [STRIDE_W-1:0] stride;
        logic [COL_W-1:0]    col;
        logic [ROW_W-1:0]    row;
        logic [7:0]          font_mem [FONT_SIZE];
        bit                  font_set [FONT_SIZE];
        row_write_t          rows_due [$];
        int                  mismatches;
        int                  rows_checked;
        int                  cells;

        function new();
            fg = tcgr_pkg::FG_RESET;
            bg = tcgr_pkg::BG_RESET;
            width = tcgr_pkg::SW_RESET;
            pitch = tcgr_pkg::PITCH_RESET;
            stride = tcgr_pkg::STRIDE_RESET;
            col = '0;
            row = '0;
            mismatches = 0;
            rows_checked = 0;
            cells = 0;
            foreach (font_set[i]) font_set[i] = 1'b0;
        endfunction

        function void write_reg(tcgr_pkg::reg_idx_t idx, logic [PIX_W-1:0] value);
            case (idx)
                tcgr_pkg::REG_FG_COLOR:     fg = value;
                tcgr_pkg::REG_BG_COLOR:     bg = value;
                tcgr_pkg::REG_SCREEN_WIDTH: width = value[SW_W-1:0];
                tcgr_pkg::REG_ROW_PITCH:    pitch = value[PITCH_W-1:0];
                tcgr_pkg::REG_GLYPH_STRIDE: stride = value[STRIDE_W-1:0];
                default: ;
            endcase
        endfunction

        function bit glyph_loaded(logic [7:0] code);
            for (int r = 0; r < CELL_ROWS; r++) begin
                if (!font_set[(int'(code) * int'(stride) + r) % FONT_SIZE]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void draw_cell(logic [7:0] code, logic [COL_W-1:0] x,
                                logic [ROW_W-1:0] y, bit erase);
            row_write_t w;
            logic [7:0] bits;
            longint a;
            for (int r = 0; r < CELL_ROWS; r++) begin
                bits = 8'd0;
                if (!erase) bits = font_mem[(int'(code) * int'(stride) + r) % FONT_SIZE];
                a = (longint'(y) + r) * longint'(pitch) + longint'(x);
                w.addr = a[ADDR_W-1:0];
                for (int k = 0; k < 8; k++) w.pix[k] = bits[7-k] ? fg : bg;
                w.last = (r == CELL_ROWS - 1);
                rows_due.push_back(w);
            end
            cells++;
        endfunction

        function void line_feed();
            col = '0;
            row = row + 16'd16;
        endfunction

        function void step_back();
            col = (col >= 12'd8) ? col - 12'd8 : 12'd0;
            draw_cell(8'd0, col, row, 1'b1);
        endfunction

        function void rub_out();
            if (col != 0) begin
                step_back();
            end else if (row != 0) begin
                row = (row >= 16'd16) ? row - 16'd16 : 16'd0;
                if (width < 8) col = '0;
                else if (int'(width) - 8 > 4095) col = 12'hFFF;
                else col = 12'(width - 8);
                if (col != 0) step_back();
            end
        endfunction

        function void take_request(logic [2:0] kind, req_fields_t f);
            int next_col;
            case (kind)
                tcgr_pkg::KIND_FONT_LOAD: begin
                    font_mem[f.font_addr] = f.font_byte;
                    font_set[f.font_addr] = 1'b1;
                end
                tcgr_pkg::KIND_PRINT: begin
                    if (f.char_code == tcgr_pkg::CHAR_NEWLINE) begin
                        line_feed();
                    end else if (f.char_code == tcgr_pkg::CHAR_BACKSPACE) begin
                        rub_out();
                    end else begin
                        draw_cell(f.char_code, col, row, 1'b0);
                        next_col = int'(col) + 8;
                        if (next_col + 8 > int'(width)) line_feed();
                        else col = next_col[COL_W-1:0];
                    end
                end
                tcgr_pkg::KIND_PLACE: draw_cell(f.char_code, f.pos_x, f.pos_y, 1'b0);
                tcgr_pkg::KIND_SET_X: col = f.pos_x;
                tcgr_pkg::KIND_NEWLINE: line_feed();
                default: ;
            endcase
        endfunction

        function void check_row(logic [M_TDATA_W-1:0] data, logic last);
            row_write_t want;
            if (rows_due.size() == 0) begin
                $display("%0t: row write with none expected, addr %h", $time,
                         data[ADDR_W-1:0]);
                mismatches++;
                return;
            end
            want = rows_due.pop_front();
            rows_checked++;
            if (data[ADDR_W-1:0] !== want.addr) begin
                $display("%0t: pixel_addr expected %h got %h", $time, want.addr,
                         data[ADDR_W-1:0]);
                mismatches++;
            end
            for (int k = 0; k < 8; k++) begin
                if (data[ADDR_W + PIX_W*k +: PIX_W] !== want.pix[k]) begin
                    $display("%0t: pixel%0d expected %h got %h", $time, k, want.pix[k],
                             data[ADDR_W + PIX_W*k +: PIX_W]);
                    mismatches++;
                end
            end
            if (last !== want.last) begin
                $display("%0t: last_row expected %b got %b", $time, want.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [2:0]            cfg_wr_idx;
    logic [PIX_W-1:0]      cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [2:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;

    console_shadow shadow = new();
    bit steady = 1'b0;
    bit squeeze = 1'b0;
    int sent_items = 0;
    int settings_used = 1;
    int cycle_count = 0;

    text_console_glyph_renderer_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_idx  (cfg_wr_idx),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic req_fields_t noise();
        req_fields_t f;
        f.char_code = 8'($urandom);
        f.pos_x = 12'($urandom);
        f.pos_y = 16'($urandom);
        f.font_addr = 13'($urandom);
        f.font_byte = 8'($urandom);
        return f;
    endfunction

    // result side: random stalls plus one long hold-off in the pressure phase
    initial begin
        int stall_left;
        int hold_left;
        bit hold_done;
        stall_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) shadow.check_row(m_tdata, m_tlast);
            if (squeeze && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                stall_left = pick_gap();
                m_tready <= (stall_left == 0);
            end
        end
    end

    task automatic issue(logic [2:0] kind, req_fields_t f);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {7'd0, f};
        do @(posedge aclk); while (!s_tready);
        shadow.take_request(kind, f);
        if (kind <= tcgr_pkg::KIND_NEWLINE) sent_items++;
    endtask

    task automatic type_char(logic [7:0] code);
        req_fields_t f;
        f = noise();
        f.char_code = code;
        issue(tcgr_pkg::KIND_PRINT, f);
    endtask

    task automatic put_glyph(logic [7:0] code, logic [COL_W-1:0] x, logic [ROW_W-1:0] y);
        req_fields_t f;
        f = noise();
        f.char_code = code;
        f.pos_x = x;
        f.pos_y = y;
        issue(tcgr_pkg::KIND_PLACE, f);
    endtask

    task automatic set_col(logic [COL_W-1:0] x);
        req_fields_t f;
        f = noise();
        f.pos_x = x;
        issue(tcgr_pkg::KIND_SET_X, f);
    endtask

    task automatic load_row(logic [7:0] code, int r, logic [7:0] bits);
        req_fields_t f;
        f = noise();
        f.font_addr = FADDR_W'((int'(code) * int'(shadow.stride) + r) % FONT_SIZE);
        f.font_byte = bits;
        issue(tcgr_pkg::KIND_FONT_LOAD, f);
    endtask

    task automatic load_glyph(logic [7:0] code);
        for (int r = 0; r < CELL_ROWS; r++) load_row(code, r, 8'($urandom));
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (shadow.rows_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic program_settings(logic [PIX_W-1:0] fg, logic [PIX_W-1:0] bg, int w,
                                    int pitch, int stride);
        tcgr_pkg::reg_idx_t idx [5];
        logic [PIX_W-1:0] val [5];
        idx = '{tcgr_pkg::REG_FG_COLOR, tcgr_pkg::REG_BG_COLOR, tcgr_pkg::REG_SCREEN_WIDTH,
                tcgr_pkg::REG_ROW_PITCH, tcgr_pkg::REG_GLYPH_STRIDE};
        val = '{fg, bg, PIX_W'(w), PIX_W'(pitch), PIX_W'(stride)};
        settle();
        for (int i = 0; i < 5; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_wr_idx <= idx[i];
            cfg_wr_data <= val[i];
            @(posedge aclk);
            shadow.write_reg(idx[i], val[i]);
        end
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic random_request();
        logic [7:0] ready [$];
        int pick;
        int span;
        logic [ROW_W-1:0] y;
        req_fields_t f;
        for (int c = 0; c < 256; c++) begin
            if (shadow.glyph_loaded(8'(c))) ready.push_back(8'(c));
        end
        pick = $urandom_range(0, 99);
        if (ready.size() == 0 || pick < 4) begin
            if ($urandom_range(0, 3) == 0) begin
                load_glyph($urandom_range(0, 1) ? tcgr_pkg::CHAR_NEWLINE
                                                : tcgr_pkg::CHAR_BACKSPACE);
            end else begin
                load_glyph(8'($urandom_range(0, 255)));
            end
        end else if (pick < 40) begin
            type_char(ready[$urandom_range(0, ready.size() - 1)]);
        end else if (pick < 50) begin
            type_char(tcgr_pkg::CHAR_BACKSPACE);
        end else if (pick < 56) begin
            type_char(tcgr_pkg::CHAR_NEWLINE);
        end else if (pick < 72) begin
            y = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 2047)) : 16'($urandom);
            put_glyph(ready[$urandom_range(0, ready.size() - 1)], 12'($urandom), y);
        end else if (pick < 80) begin
            span = int'(shadow.width) / 8 - 1;
            if ($urandom_range(0, 1) && span >= 0) set_col(12'($urandom_range(0, span) * 8));
            else set_col(12'($urandom));
        end else if (pick < 85) begin
            issue(tcgr_pkg::KIND_NEWLINE, noise());
        end else if (pick < 96) begin
            issue(tcgr_pkg::KIND_FONT_LOAD, noise());
        end else begin
            f = noise();
            issue(3'($urandom_range(int'(tcgr_pkg::KIND_NEWLINE) + 1, 7)), f);
        end
    endtask

    task automatic random_phase();
        int target;
        target = sent_items + PHASE_ITEMS;
        while (sent_items < target) random_request();
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_idx = '0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // font setup, with extreme row patterns on the last code
        load_glyph(8'd0);
        load_glyph(tcgr_pkg::CHAR_BACKSPACE);
        load_glyph(tcgr_pkg::CHAR_NEWLINE);
        load_glyph(8'd255);
        load_row(8'd255, 0, 8'hFF);
        load_row(8'd255, 1, 8'h00);
        load_row(8'd255, 2, 8'h80);
        load_row(8'd255, 3, 8'h01);

        // directed requests at reset settings
        type_char(8'd0);
        type_char(8'd255);
        type_char(tcgr_pkg::CHAR_BACKSPACE);
        type_char(tcgr_pkg::CHAR_NEWLINE);
        type_char(tcgr_pkg::CHAR_BACKSPACE);
        set_col(12'd0);
        type_char(tcgr_pkg::CHAR_BACKSPACE);
        set_col(12'hFFF);
        type_char(8'd255);
        set_col(12'd3);
        type_char(tcgr_pkg::CHAR_BACKSPACE);
        set_col(12'd624);
        type_char(8'd0);
        type_char(8'd0);
        put_glyph(8'd255, 12'hFFF, 16'hFFFF);
        put_glyph(8'd0, 12'd0, 16'd0);
        put_glyph(tcgr_pkg::CHAR_BACKSPACE, 12'd17, 16'd300);
        put_glyph(tcgr_pkg::CHAR_NEWLINE, 12'd1000, 16'd5);
        issue(tcgr_pkg::KIND_NEWLINE, noise());
        for (int k = int'(tcgr_pkg::KIND_NEWLINE) + 1; k < 8; k++) issue(3'(k), noise());
        random_phase();

        program_settings(32'($urandom), 32'($urandom), 16, 16, 16);
        random_phase();

        steady = 1'b1;
        program_settings(32'hFFFF_FFFF, 32'h0000_0000, 4096, 8192, 32);
        random_phase();
        steady = 1'b0;

        program_settings(32'($urandom), 32'($urandom), $urandom_range(16, 4096),
                         $urandom_range(16, 8192), $urandom_range(16, 32));
        squeeze = 1'b1;
        random_phase();

        program_settings(32'h0000_0000, 32'hFFFF_FFFF, $urandom_range(16, 4096),
                         $urandom_range(16, 1024), $urandom_range(17, 31));
        random_phase();

        settle();
        $display("run covered %0d requests over %0d register settings", sent_items,
                 settings_used);
        $display("%0d cells drawn, %0d row writes checked, %0d mismatches", shadow.cells,
                 shadow.rows_checked, shadow.mismatches);
        if (shadow.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
